[design/rth_pkg.sv]
// Shared types and constants for the RGB to HSV converter.
// No dependencies; used by the interfaces, the cells and the top level.
package rth_pkg;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned REM_W  = 2 * CH_W;
    localparam int unsigned NCELLS = CH_W;
    localparam int unsigned NSTG   = NCELLS + 2;

    localparam logic [CH_W-1:0] HUE_SPAN       = 8'd43;
    localparam logic [CH_W-1:0] HUE_BASE_RED   = 8'd0;
    localparam logic [CH_W-1:0] HUE_BASE_GREEN = 8'd85;
    localparam logic [CH_W-1:0] HUE_BASE_BLUE  = 8'd171;

    typedef logic [CH_W-1:0] t_chan;

    // Payload carried from cell to cell: two restoring divisions side by side.
    typedef struct packed {
        logic [REM_W-1:0] sat_rem;  // 255*chroma, reduced as bits are found
        logic [REM_W-1:0] hue_rem;  // 43*|diff|, reduced as bits are found
        t_chan            sat_q;
        t_chan            hue_q;
        t_chan            hi;       // divisor for saturation, also brightness
        t_chan            chroma;   // divisor for hue
        t_chan            base;
        logic             neg;      // hue offset is subtracted
    } t_cell_data;

endpackage

[design/rth_pix_if.sv]
// Input channel: one RGB pixel per transfer.
// Depends on rth_pkg.
interface rth_pix_if;
    logic          valid;
    logic          ready;
    rth_pkg::t_chan red;
    rth_pkg::t_chan green;
    rth_pkg::t_chan blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

[design/rth_hsv_if.sv]
// Output channel: one HSV result per transfer.
// Depends on rth_pkg.
interface rth_hsv_if;
    logic          valid;
    logic          ready;
    rth_pkg::t_chan hue;
    rth_pkg::t_chan saturation;
    rth_pkg::t_chan brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

[design/rth_prep.sv]
// Front stage: max/min, chroma, hue base and signed channel difference,
// plus the two dividends. Registered. Depends on rth_pkg.
module rth_prep (
    input  logic                i_clk,
    input  logic                i_en,
    input  rth_pkg::t_chan      i_red,
    input  rth_pkg::t_chan      i_green,
    input  rth_pkg::t_chan      i_blue,
    output rth_pkg::t_cell_data o_data
);

    rth_pkg::t_cell_data r_data;
    rth_pkg::t_cell_data n_data;

    rth_pkg::t_chan hi;
    rth_pkg::t_chan lo;
    rth_pkg::t_chan pa;
    rth_pkg::t_chan pb;
    rth_pkg::t_chan mag;
    logic           neg;

    always_comb begin
        hi = (i_red > i_green) ? i_red : i_green;
        hi = (hi > i_blue) ? hi : i_blue;
        lo = (i_red < i_green) ? i_red : i_green;
        lo = (lo < i_blue) ? lo : i_blue;

        // red wins ties over green, green over blue
        if (hi == i_red) begin
            n_data.base = rth_pkg::HUE_BASE_RED;
            pa = i_green;
            pb = i_blue;
        end else if (hi == i_green) begin
            n_data.base = rth_pkg::HUE_BASE_GREEN;
            pa = i_blue;
            pb = i_red;
        end else begin
            n_data.base = rth_pkg::HUE_BASE_BLUE;
            pa = i_red;
            pb = i_green;
        end
        neg = (pb > pa);
        mag = neg ? (pb - pa) : (pa - pb);

        n_data.hi      = hi;
        n_data.chroma  = hi - lo;
        n_data.neg     = neg;
        // 255*c = (c << 8) - c
        n_data.sat_rem = {n_data.chroma, {rth_pkg::CH_W{1'b0}}}
                         - {{rth_pkg::CH_W{1'b0}}, n_data.chroma};
        n_data.hue_rem = rth_pkg::REM_W'(mag) * rth_pkg::REM_W'(rth_pkg::HUE_SPAN);
        n_data.sat_q   = '0;
        n_data.hue_q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

[design/rth_cell.sv]
// One restoring-division cell: finds quotient bit BIT of both the saturation
// and the hue divisions, then registers the payload. Depends on rth_pkg.
module rth_cell #(
    parameter int unsigned BIT = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  rth_pkg::t_cell_data i_data,
    output rth_pkg::t_cell_data o_data
);

    rth_pkg::t_cell_data r_data;
    rth_pkg::t_cell_data n_data;

    logic [rth_pkg::REM_W-1:0] sat_sh;
    logic [rth_pkg::REM_W-1:0] hue_sh;
    logic                      sat_bit;
    logic                      hue_bit;

    always_comb begin
        sat_sh  = rth_pkg::REM_W'(i_data.hi) << BIT;
        hue_sh  = rth_pkg::REM_W'(i_data.chroma) << BIT;
        sat_bit = (i_data.sat_rem >= sat_sh);
        hue_bit = (i_data.hue_rem >= hue_sh);

        n_data = i_data;
        if (sat_bit) begin
            n_data.sat_rem = i_data.sat_rem - sat_sh;
        end
        if (hue_bit) begin
            n_data.hue_rem = i_data.hue_rem - hue_sh;
        end
        n_data.sat_q[BIT] = sat_bit;
        n_data.hue_q[BIT] = hue_bit;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

[design/rgb_to_hsv_8bit.sv]
// RGB to HSV converter, 8 bits per channel.
// Pipeline from input transfer to result valid: front stage,
// one cell per quotient bit for 8 bits, output register.
// Throughput: one pixel per cycle; each stage advances when its successor
// is empty or advancing. Synchronous active-low reset clears all valid bits.
// Depends on rth_pkg, rth_pix_if, rth_hsv_if, rth_prep, rth_cell.
module rgb_to_hsv_8bit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rth_pix_if.sink     i_pix,
    rth_hsv_if.source   o_hsv
);

    localparam int unsigned NC = rth_pkg::NCELLS;
    localparam int unsigned NS = rth_pkg::NSTG;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] en;

    rth_pkg::t_cell_data d [NC+1];

    rth_pkg::t_chan r_hue;
    rth_pkg::t_chan r_sat;
    rth_pkg::t_chan r_val;
    rth_pkg::t_chan n_hue;
    rth_pkg::t_chan n_sat;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || o_hsv.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[0] = en[0] ? i_pix.valid : r_vld[0];
        for (int k = 1; k < NS; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    rth_prep u_prep (
        .i_clk   (i_clk),
        .i_en    (en[0]),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_data  (d[0])
    );

    // cell j resolves quotient bit NC-1-j, most significant first
    for (genvar j = 0; j < NC; j++) begin : g_cell
        rth_cell #(
            .BIT (NC - 1 - j)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (en[j+1]),
            .i_data (d[j]),
            .o_data (d[j+1])
        );
    end

    always_comb begin
        // black pixel: divisor of saturation was zero, quotient is junk
        n_sat = (d[NC].hi == '0) ? '0 : d[NC].sat_q;
        if (d[NC].hi == '0 || d[NC].chroma == '0) begin
            n_hue = '0;
        end else if (d[NC].neg) begin
            n_hue = d[NC].base - d[NC].hue_q;
        end else begin
            n_hue = d[NC].base + d[NC].hue_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= d[NC].hi;
        end
    end

    assign i_pix.ready      = en[0];
    assign o_hsv.valid      = r_vld[NS-1];
    assign o_hsv.hue        = r_hue;
    assign o_hsv.saturation = r_sat;
    assign o_hsv.brightness = r_val;

endmodule
